// ===== rtl/gwt_pkg.sv =====
// Shared types and constants for the grouped watcher table.
// No dependencies.
package gwt_pkg;
    localparam int unsigned MAX_WATCHERS = 16;
    localparam int unsigned ID_BITS      = 16;
    localparam int unsigned SLOT_BITS    = $clog2(MAX_WATCHERS);
    localparam int unsigned CNT_BITS     = $clog2(MAX_WATCHERS + 1);

    localparam logic [1:0] REQ_ACTIVATE = 2'd0;
    localparam logic [1:0] REQ_ESTABLISH = 2'd1;
    localparam logic [1:0] REQ_DESTROY  = 2'd2;
    localparam logic [1:0] REQ_QUERY    = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;

    typedef struct packed {
        logic       exec;
        logic [1:0] req;
    } gwt_cmd_t;

    typedef struct packed {
        logic hit;
    } gwt_stat_t;
endpackage

// ===== rtl/gwt_ctrl.sv =====
// Controller: handshake state machine for the grouped watcher table.
// Depends on gwt_pkg.
module gwt_ctrl import gwt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    output logic       m_valid,
    input  logic       m_ready,
    output gwt_cmd_t   cmd
);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_HOLD = 1'b1;

    logic state_reg, state_next;

    // take a word when output slot is free or being drained
    assign s_ready   = (state_reg == ST_IDLE) || m_ready;
    assign m_valid   = (state_reg == ST_HOLD);
    assign cmd.exec  = s_valid && s_ready;
    assign cmd.req   = s_req_type;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (cmd.exec) state_next = ST_HOLD;
            ST_HOLD: if (m_ready && !cmd.exec) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end
endmodule

// ===== rtl/gwt_datapath.sv =====
// Datapath: slot table, group counters and result register.
// Depends on gwt_pkg.
module gwt_datapath import gwt_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  gwt_cmd_t            cmd,
    input  logic [15:0]         s_watcher_id,
    output gwt_stat_t           stat,
    output logic                m_is_active,
    output logic [3:0]          m_group_position,
    output logic [4:0]          m_groups_in_use,
    output logic [4:0]          m_groups_allowed,
    output logic [1:0]          m_status
);
    logic [MAX_WATCHERS-1:0] valid_reg, valid_next;
    logic [ID_BITS-1:0]      id_reg [MAX_WATCHERS];
    logic [SLOT_BITS-1:0]    grp_reg [MAX_WATCHERS], grp_next [MAX_WATCHERS];
    logic [CNT_BITS-1:0]     total_reg, total_next, allow_reg, allow_next;
    logic                    pend_reg, pend_next;
    logic [ID_BITS-1:0]      id;
    logic [MAX_WATCHERS-1:0] match, free;
    logic [SLOT_BITS-1:0]    hit_slot, free_slot, new_grp, dgrp;
    logic                    hit, any_free, still_used, wr;
    logic [1:0]              st;
    logic                    o_act;
    logic [SLOT_BITS-1:0]    o_pos;

    assign id = s_watcher_id[ID_BITS-1:0];
    assign stat.hit = hit;

    always_comb begin
        hit_slot = '0; free_slot = '0; hit = 1'b0; any_free = 1'b0;
        for (int i = MAX_WATCHERS - 1; i >= 0; i--) begin
            match[i] = valid_reg[i] && id_reg[i] == id;
            free[i]  = !valid_reg[i];
            if (match[i]) begin hit = 1'b1; hit_slot = SLOT_BITS'(i); end
            if (free[i]) begin any_free = 1'b1; free_slot = SLOT_BITS'(i); end
        end
    end

    always_comb begin
        valid_next = valid_reg; grp_next = grp_reg;
        total_next = total_reg; allow_next = allow_reg; pend_next = pend_reg;
        st = ST_OK; wr = 1'b0; new_grp = '0; still_used = 1'b0;
        dgrp = grp_reg[hit_slot];
        o_act = 1'b0; o_pos = '0;
        case (cmd.req)
            REQ_ACTIVATE: begin
                if (pend_reg && allow_reg < CNT_BITS'(MAX_WATCHERS))
                    allow_next = allow_reg + 1'b1;
                pend_next = 1'b0;
                o_act = hit;
                if (hit) o_pos = dgrp;
            end
            REQ_ESTABLISH: begin
                if (hit) begin
                    st = ST_DUPLICATE; o_act = 1'b1; o_pos = dgrp;
                end else if (!any_free) begin
                    st = ST_FULL;
                end else begin
                    if (total_reg < allow_reg) begin
                        new_grp = SLOT_BITS'(total_reg);
                        total_next = total_reg + 1'b1;
                    end else if (total_reg != '0) begin
                        new_grp = SLOT_BITS'(total_reg - 1'b1);
                    end
                    wr = 1'b1;
                    valid_next[free_slot] = 1'b1;
                    grp_next[free_slot] = new_grp;
                    pend_next = 1'b1;
                    o_act = 1'b1; o_pos = new_grp;
                end
            end
            REQ_DESTROY: begin
                if (hit) begin
                    valid_next[hit_slot] = 1'b0;
                    for (int i = 0; i < MAX_WATCHERS; i++)
                        if (valid_reg[i] && !match[i] && grp_reg[i] == dgrp)
                            still_used = 1'b1;
                    if (!still_used) begin
                        for (int i = 0; i < MAX_WATCHERS; i++)
                            if (valid_reg[i] && grp_reg[i] > dgrp)
                                grp_next[i] = grp_reg[i] - 1'b1;
                        if (total_reg != '0) total_next = total_reg - 1'b1;
                    end
                end
            end
            default: begin
                o_act = hit;
                if (hit) o_pos = dgrp;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0; total_reg <= '0;
            allow_reg <= CNT_BITS'(1); pend_reg <= 1'b1;
        end else if (cmd.exec) begin
            valid_reg <= valid_next; total_reg <= total_next;
            allow_reg <= allow_next; pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            grp_reg <= grp_next;
            if (wr) id_reg[free_slot] <= id;
            m_is_active      <= o_act;
            m_group_position <= 4'(o_pos);
            m_groups_in_use  <= 5'(total_next);
            m_groups_allowed <= 5'(allow_next);
            m_status         <= st;
        end
    end
endmodule

// ===== rtl/grouped_watcher_table_unit.sv =====
// Top level of the grouped watcher table.
// Depends on gwt_pkg, gwt_ctrl, gwt_datapath.
//
//  channel | ports                                  | direction
//  input   | s_valid s_ready s_req_type s_watcher_id | in
//  result  | m_valid m_ready m_is_active ...         | out
//
// For each word, all 16 slots are compared and renumbered in parallel, and
// the result lands in the output register at the accept edge. A new word
// is taken in the cycle the held result drains, so one word per cycle is
// sustained unless a stalled result holds and blocks input. Reset empties
// the table, groups to zero, allowance to one and arms the pending flag.
module grouped_watcher_table_unit import gwt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [15:0] s_watcher_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_active,
    output logic [3:0]  m_group_position,
    output logic [4:0]  m_groups_in_use,
    output logic [4:0]  m_groups_allowed,
    output logic [1:0]  m_status
);
    gwt_cmd_t  cmd;
    gwt_stat_t stat;

    // sequence words through the output register
    gwt_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_req_type,
        .m_valid, .m_ready, .cmd
    );

    // lookup, update and register the result
    gwt_datapath u_dp (
        .aclk, .aresetn, .cmd, .s_watcher_id, .stat,
        .m_is_active, .m_group_position, .m_groups_in_use,
        .m_groups_allowed, .m_status
    );
endmodule

// ===== rtl/gwt_checker.sv =====
// Port-level checks for grouped_watcher_table_unit, bound to the top level.
// No package dependency.
module gwt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_is_active,
    input logic [3:0] m_group_position,
    input logic [4:0] m_groups_in_use,
    input logic [4:0] m_groups_allowed,
    input logic [1:0] m_status
);
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result changed while stalled");
    a_allow_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_groups_allowed != 5'd0 && m_groups_allowed <= 5'd16)
        else $error("allowance out of range");
    a_inactive_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_active |-> m_group_position == 4'd0)
        else $error("position without active id");
    a_pos_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_active |-> {1'b0, m_group_position} < m_groups_in_use)
        else $error("position beyond groups in use");
    a_accept_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted word produced no result");
endmodule

bind grouped_watcher_table_unit gwt_checker u_gwt_checker (.*);
